[sv/rtc_raw_to_local_time_defines.svh]
// Assertion helpers used by the top-level RTL module.
`ifndef RTC_RAW_TO_LOCAL_TIME_DEFINES_SVH
`define RTC_RAW_TO_LOCAL_TIME_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define RTLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define RTLT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rtlt_pkg.sv]
package rtlt_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [10:0] TZ_MIN = -11'sd720;
    localparam logic signed [10:0] TZ_MAX = 11'sd840;

    localparam logic signed [15:0] MIN_PER_DAY = 16'sd1440;

    // floor(r * 1093 / 2^16) == r / 60 for r < 1440
    localparam logic [10:0] DIV60_RECIP = 11'd1093;
    localparam int          DIV60_SHIFT = 16;

    localparam int SB_BINARY_BIT = 2;
    localparam int SB_24H_BIT    = 1;
    localparam int HOUR_PM_BIT   = 7;

    typedef struct packed {
        logic [7:0] raw_second;
        logic [7:0] raw_minute;
        logic [7:0] raw_hour;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
        logic [7:0] status_b;
    } t_raw_item;

    typedef struct packed {
        logic [7:0] local_second;
        logic [5:0] local_minute;
        logic [4:0] local_hour;
        logic [7:0] local_day;
        logic [7:0] local_month;
        logic [6:0] local_year;
    } t_local_item;

    // Decoded snapshot waiting for the day carry; year_ofs is year - 2000.
    typedef struct packed {
        logic [7:0]        second;
        logic signed [15:0] mod;
        logic [7:0]        day;
        logic [7:0]        month;
        logic signed [9:0] year_ofs;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CARRY,
        BK_SPLIT
    } t_back_state;

    // Year offset stays within -1..256, so only 2100 and 2200 drop out.
    function automatic logic is_leap(input logic signed [9:0] yo);
        return (yo[1:0] == 2'b00) && (yo != 10'sd100) && (yo != 10'sd200);
    endfunction

    function automatic logic [7:0] days_in_month(input logic signed [9:0] yo,
                                                 input logic [7:0] m);
        logic [7:0] d;
        unique case (m) inside
            8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: d = 8'd31;
            8'd4, 8'd6, 8'd9, 8'd11:                    d = 8'd30;
            8'd2:                                       d = is_leap(yo) ? 8'd29 : 8'd28;
            default:                                    d = 8'd30;
        endcase
        return d;
    endfunction

endpackage

[sv/rtlt_front.sv]
module rtlt_front import rtlt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic signed [10:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    input  t_raw_item           i_raw,
    input  t_queue_status       i_q_status,
    output logic                o_in_ready,
    output logic                o_push,
    output t_job                o_job
);

    logic signed [10:0] r_tz;

    logic               binary;
    logic [7:0]         sec;
    logic [7:0]         mins;
    logic [7:0]         hr_dec;
    logic [7:0]         hr;
    logic [7:0]         day;
    logic [7:0]         mon;
    logic [7:0]         yr;
    logic [6:0]         hr_tens;
    logic [7:0]         pm_sum;
    logic [15:0]        hr16;
    logic [15:0]        hr_min;

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]};
        return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
    endfunction

    // v % 24; the caller passes hour + 12, so v <= 139
    function automatic logic [7:0] mod24(input logic [7:0] v);
        logic [7:0] t;
        t = v;
        if (t >= 8'd96) t = t - 8'd96;
        if (t >= 8'd48) t = t - 8'd48;
        if (t >= 8'd24) t = t - 8'd24;
        return t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata < TZ_MIN) begin
                r_tz <= TZ_MIN;
            end else if (i_cfg_wdata > TZ_MAX) begin
                r_tz <= TZ_MAX;
            end else begin
                r_tz <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        binary  = i_raw.status_b[SB_BINARY_BIT];
        hr_tens = {4'd0, i_raw.raw_hour[6:4]};
        sec     = binary ? i_raw.raw_second : from_bcd(i_raw.raw_second);
        mins    = binary ? i_raw.raw_minute : from_bcd(i_raw.raw_minute);
        day     = binary ? i_raw.raw_day    : from_bcd(i_raw.raw_day);
        mon     = binary ? i_raw.raw_month  : from_bcd(i_raw.raw_month);
        yr      = binary ? i_raw.raw_year   : from_bcd(i_raw.raw_year);
        // decoded low part is at most 85, so the PM bit sits on top untouched
        hr_dec  = binary ? i_raw.raw_hour
                         : {i_raw.raw_hour[HOUR_PM_BIT],
                            (hr_tens << 3) + (hr_tens << 1) + {3'd0, i_raw.raw_hour[3:0]}};
        pm_sum  = {1'b0, hr_dec[6:0]} + 8'd12;
        if (!i_raw.status_b[SB_24H_BIT] && hr_dec[HOUR_PM_BIT]) begin
            hr = mod24(pm_sum);
        end else begin
            hr = hr_dec;
        end
        hr16   = {8'd0, hr};
        hr_min = (hr16 << 6) - (hr16 << 2) + {8'd0, mins};

        o_job.second   = sec;
        o_job.mod      = $signed(hr_min) + {{5{r_tz[10]}}, r_tz};
        o_job.day      = day;
        o_job.month    = mon;
        o_job.year_ofs = {2'b00, yr};
    end

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

endmodule

[sv/rtlt_queue.sv]
module rtlt_queue import rtlt_pkg::*; #(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_job,
    output t_queue_status o_status
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job          = r_mem[r_rd];
    assign o_status.full  = (r_count == CntW'(Depth));
    assign o_status.empty = (r_count == '0);

endmodule

[sv/rtlt_back.sv]
module rtlt_back import rtlt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_job,
    input  t_queue_status i_q_status,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output t_local_item   o_out_data
);

    t_back_state        r_state, n_state;
    logic signed [15:0] r_mod, n_mod;
    logic [7:0]         r_day, n_day;
    logic [7:0]         r_month, n_month;
    logic signed [9:0]  r_yo, n_yo;
    logic [7:0]         r_sec, n_sec;
    logic [4:0]         r_quot, n_quot;
    logic               r_out_valid, n_out_valid;
    t_local_item        r_out, n_out;

    logic [21:0]        prod;
    logic [10:0]        q11;
    logic [10:0]        rem;
    logic [7:0]         mo_prev;
    logic signed [9:0]  yo_prev;
    logic [9:0]         yo_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mod   <= n_mod;
        r_day   <= n_day;
        r_month <= n_month;
        r_yo    <= n_yo;
        r_sec   <= n_sec;
        r_quot  <= n_quot;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_mod       = r_mod;
        n_day       = r_day;
        n_month     = r_month;
        n_yo        = r_yo;
        n_sec       = r_sec;
        n_quot      = r_quot;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;

        prod    = r_mod[10:0] * DIV60_RECIP;
        q11     = {6'd0, r_quot};
        rem     = r_mod[10:0] - ((q11 << 6) - (q11 << 2));
        mo_prev = (r_month <= 8'd1) ? 8'd12 : r_month - 8'd1;
        yo_prev = (r_month <= 8'd1) ? r_yo - 10'sd1 : r_yo;
        yo_u    = r_yo;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_mod   = i_job.mod;
                    n_day   = i_job.day;
                    n_month = i_job.month;
                    n_yo    = i_job.year_ofs;
                    n_sec   = i_job.second;
                    n_state = BK_CARRY;
                end
            end
            BK_CARRY: begin
                // one whole day per cycle
                if (r_mod < 16'sd0) begin
                    n_mod = r_mod + MIN_PER_DAY;
                    if (r_day <= 8'd1) begin
                        n_month = mo_prev;
                        n_yo    = yo_prev;
                        n_day   = days_in_month(yo_prev, mo_prev);
                    end else begin
                        n_day = r_day - 8'd1;
                    end
                end else if (r_mod >= MIN_PER_DAY) begin
                    n_mod = r_mod - MIN_PER_DAY;
                    if (r_day >= days_in_month(r_yo, r_month)) begin
                        n_day = 8'd1;
                        if (r_month >= 8'd12) begin
                            n_month = 8'd1;
                            n_yo    = r_yo + 10'sd1;
                        end else begin
                            n_month = r_month + 8'd1;
                        end
                    end else begin
                        n_day = r_day + 8'd1;
                    end
                end else begin
                    n_quot  = 5'(prod >> DIV60_SHIFT);
                    n_state = BK_SPLIT;
                end
            end
            BK_SPLIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.local_second = r_sec;
                    n_out.local_minute = rem[5:0];
                    n_out.local_hour   = r_quot;
                    n_out.local_day    = r_day;
                    n_out.local_month  = r_month;
                    // 1999 wraps to 99
                    if (r_yo < 10'sd0) begin
                        n_out.local_year = 7'd99;
                    end else if (r_yo < 10'sd100) begin
                        n_out.local_year = yo_u[6:0];
                    end else if (r_yo < 10'sd200) begin
                        n_out.local_year = 7'(yo_u - 10'd100);
                    end else begin
                        n_out.local_year = 7'(yo_u - 10'd200);
                    end
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/rtc_raw_to_local_time.sv]
// Converts one snapshot of raw RTC registers (BCD or binary, 12- or 24-hour)
// into local time with a signed timezone offset in minutes, carrying days
// through the Gregorian calendar from year 2000. The front end decodes a
// snapshot and takes a new transaction every cycle while its small queue has
// room. The back end carries one whole day per cycle, D days in all (0..11;
// a negative offset carries at most one day back): it takes a snapshot from
// the queue, carries each day, splits the minutes into hour and minute, then
// loads the result register, waiting while an earlier result is not yet taken.
// The result register lets the next snapshot proceed while a result
// waits to be taken. The offset register clamps writes to -720..840 and must
// only be written while no transaction is in flight.
`include "rtc_raw_to_local_time_defines.svh"

module rtc_raw_to_local_time import rtlt_pkg::*; #(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [10:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_raw_item          i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_local_item        o_out_data
);

    t_job          front_job;
    t_job          queue_job;
    t_queue_status q_status;
    logic          q_push;
    logic          q_pop;
    logic          out_in_range;

    rtlt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_raw       (i_in_data),
        .i_q_status  (q_status),
        .o_in_ready  (o_in_ready),
        .o_push      (q_push),
        .o_job       (front_job)
    );

    rtlt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (front_job),
        .i_pop    (q_pop),
        .o_job    (queue_job),
        .o_status (q_status)
    );

    rtlt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign out_in_range = (o_out_data.local_minute < 6'd60) && (o_out_data.local_hour < 5'd24)
                       && (o_out_data.local_year < 7'd100);

    `RTLT_ASSERT_IMP(a_pop_not_empty, q_pop, !q_status.empty, "queue popped while empty")
    `RTLT_ASSERT_NXT(a_push_lands, q_push, !q_status.empty, "pushed transaction vanished")
    `RTLT_ASSERT_IMP(a_result_range, o_out_valid && i_out_ready, out_in_range, "result out of range")

endmodule
